// ===== src/sat_pkg.sv =====
package sat_pkg;

   localparam int STATE_W   = 2;
   localparam int DAYS_W    = 16;
   localparam int PROB_W    = 64;
   localparam int CONTACT_W = 5;
   localparam int MASK_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [STATE_W-1:0] ST_SUS = 2'd0;
   localparam logic [STATE_W-1:0] ST_EXP = 2'd1;
   localparam logic [STATE_W-1:0] ST_INF = 2'd2;
   localparam logic [STATE_W-1:0] ST_REC = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCUBATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE      = 2'd3;

   localparam int MAX_CONTACTS = 16;

   // twister generator
   localparam int          TW_N      = 624;
   localparam int          TW_M      = 397;
   localparam int          TW_W      = 32;
   localparam int          TW_AW     = $clog2(TW_N);
   localparam logic [31:0] SEED_MULT = 32'd1812433253;
   localparam logic [31:0] TW_MATRIX = 32'h9908b0df;
   localparam logic [31:0] SEED_DEFAULT = 32'd5489;

   typedef struct packed {
      logic seed_start;
      logic seed_mul;
      logic seed_add;
      logic load_item;
      logic next_contact;
      logic gen_lo;
      logic gen_hi;
      logic apply;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic seed_last;
      logic is_sus;
      logic is_rec;
      logic contacts_done;
      logic mask_bit;
      logic success;
   } status_type;

endpackage

// ===== src/seir_agent_transition_unit.sv =====
// Stochastic SEIR update of one agent per request word, using an on-chip
// MT19937 generator whose 624-word state lives in a dual-read RAM and is
// regenerated one word at a time as words are consumed. After reset and
// after every seed CSR write the generator state is refilled, with
// req_ready low while the fill runs. One draw reads and generates a low
// generator word, then a high one, then compares the pair with the
// probability. A recovered agent makes no draw, an exposed or infected
// agent one draw, and a susceptible agent draws for each infectious
// contact, up to 16, until one draw succeeds. The next request can be
// taken from the cycle after the result word is loaded.
module seir_agent_transition_unit #(
   parameter int MAX_CONTACTS = sat_pkg::MAX_CONTACTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sat_pkg::STATE_W-1:0]    req_agent_state,
   input  logic [sat_pkg::DAYS_W-1:0]     req_days_sick,
   input  logic [sat_pkg::PROB_W-1:0]     req_catch_prob,
   input  logic [sat_pkg::CONTACT_W-1:0]  req_contact_total,
   input  logic [sat_pkg::MASK_W-1:0]     req_infectious_mask,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sat_pkg::STATE_W-1:0]    rsp_new_state,
   output logic [sat_pkg::DAYS_W-1:0]     rsp_new_days_sick,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sat_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0] csr_data
);

   sat_pkg::cmd_type    cmd;
   sat_pkg::status_type status;

   assign csr_ready = 1'b1;

   sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .cmd       (cmd),
      .status    (status)
   );

   sat_dp #(
      .MAX_CONTACTS (MAX_CONTACTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_agent_state     (req_agent_state),
      .req_days_sick       (req_days_sick),
      .req_catch_prob      (req_catch_prob),
      .req_contact_total   (req_contact_total),
      .req_infectious_mask (req_infectious_mask),
      .rsp_new_state       (rsp_new_state),
      .rsp_new_days_sick   (rsp_new_days_sick)
   );

endmodule

// ===== src/sat_ram.sv =====
module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== src/sat_dp.sv =====
module sat_dp #(
   parameter int MAX_CONTACTS = sat_pkg::MAX_CONTACTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sat_pkg::cmd_type                 cmd,
   output sat_pkg::status_type              status,
   input  logic                             csr_we,
   input  logic [sat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [sat_pkg::STATE_W-1:0]      req_agent_state,
   input  logic [sat_pkg::DAYS_W-1:0]       req_days_sick,
   input  logic [sat_pkg::PROB_W-1:0]       req_catch_prob,
   input  logic [sat_pkg::CONTACT_W-1:0]    req_contact_total,
   input  logic [sat_pkg::MASK_W-1:0]       req_infectious_mask,
   output logic [sat_pkg::STATE_W-1:0]      rsp_new_state,
   output logic [sat_pkg::DAYS_W-1:0]       rsp_new_days_sick
);

   localparam int AW = sat_pkg::TW_AW;
   localparam logic [AW-1:0] LAST_ADDR = AW'(sat_pkg::TW_N - 1);
   localparam logic [AW-1:0] WRAP_AT   = AW'(sat_pkg::TW_N - sat_pkg::TW_M);
   localparam logic [AW-1:0] M_OFFSET  = AW'(sat_pkg::TW_M);
   localparam int LIM_CAP = (MAX_CONTACTS < sat_pkg::MASK_W) ?
                            MAX_CONTACTS : sat_pkg::MASK_W;
   localparam logic [sat_pkg::CONTACT_W-1:0] LIM_MAX = sat_pkg::CONTACT_W'(LIM_CAP);
   localparam logic [sat_pkg::DAYS_W-1:0] DAYS_MAX = '1;

   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   logic [sat_pkg::PROB_W-1:0]    recovery_ff, incubation_ff;
   logic [31:0]                   seed_ff;
   logic [31:0]                   seed_p_ff, seed_prod_ff;
   logic [AW-1:0]                 seed_idx_ff;
   logic [AW-1:0]                 pos_ff;
   logic [31:0]                   carry_ff;
   logic [sat_pkg::STATE_W-1:0]   st_ff;
   logic [sat_pkg::DAYS_W-1:0]    days_ff;
   logic [sat_pkg::PROB_W-1:0]    prob_ff;
   logic [sat_pkg::CONTACT_W-1:0] lim_ff, j_ff;
   logic [sat_pkg::MASK_W-1:0]    mask_ff;
   logic [31:0]                   lo_ff, hi_ff;
   logic [sat_pkg::STATE_W-1:0]   rsp_state_ff;
   logic [sat_pkg::DAYS_W-1:0]    rsp_days_ff;

   logic [31:0]   seed_p_in;
   logic [AW-1:0] addr_a, addr_b, wr_addr;
   logic [31:0]   rd_a, rd_b, wr_data, mix_y, gen_word, tempered;
   logic          wr_en;

   assign seed_p_in = seed_prod_ff + {{(32-AW){1'b0}}, seed_idx_ff};

   assign addr_a = (pos_ff == LAST_ADDR) ? '0 : pos_ff + AW'(1);
   assign addr_b = (pos_ff >= WRAP_AT) ? pos_ff - WRAP_AT : pos_ff + M_OFFSET;

   // old word at pos is held in carry_ff, read as pos+1 by the step before
   assign mix_y    = {carry_ff[31], rd_a[30:0]};
   assign gen_word = rd_b ^ (mix_y >> 1) ^ (mix_y[0] ? sat_pkg::TW_MATRIX : 32'd0);
   assign tempered = temper(gen_word);

   assign wr_en = cmd.seed_start | cmd.seed_add | cmd.gen_lo | cmd.gen_hi;

   always_comb begin
      if (cmd.seed_start) begin
         wr_addr = '0;
         wr_data = seed_ff;
      end else if (cmd.seed_add) begin
         wr_addr = seed_idx_ff;
         wr_data = seed_p_in;
      end else begin
         wr_addr = pos_ff;
         wr_data = gen_word;
      end
   end

   sat_ram #(
      .WIDTH (sat_pkg::TW_W),
      .DEPTH (sat_pkg::TW_N)
   ) u_words (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         recovery_ff   <= '0;
         incubation_ff <= '0;
         seed_ff       <= sat_pkg::SEED_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            sat_pkg::CSR_RECOVERY:   recovery_ff   <= csr_data;
            sat_pkg::CSR_INCUBATION: incubation_ff <= csr_data;
            sat_pkg::CSR_SEED:       seed_ff       <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_start) begin
         seed_p_ff   <= seed_ff;
         seed_idx_ff <= AW'(1);
         carry_ff    <= seed_ff;
         pos_ff      <= '0;
      end
      if (cmd.seed_mul) begin
         seed_prod_ff <= sat_pkg::SEED_MULT * (seed_p_ff ^ (seed_p_ff >> 30));
      end
      if (cmd.seed_add) begin
         seed_p_ff   <= seed_p_in;
         seed_idx_ff <= seed_idx_ff + AW'(1);
      end
      if (cmd.gen_lo | cmd.gen_hi) begin
         carry_ff <= rd_a;
         pos_ff   <= addr_a;
      end
      if (cmd.gen_lo) lo_ff <= tempered;
      if (cmd.gen_hi) hi_ff <= tempered;

      if (cmd.load_item) begin
         st_ff   <= req_agent_state;
         days_ff <= (req_agent_state == sat_pkg::ST_INF && req_days_sick != DAYS_MAX) ?
                    req_days_sick + sat_pkg::DAYS_W'(1) : req_days_sick;
         case (req_agent_state)
            sat_pkg::ST_INF: prob_ff <= recovery_ff;
            sat_pkg::ST_EXP: prob_ff <= incubation_ff;
            default:         prob_ff <= req_catch_prob;
         endcase
         lim_ff  <= (req_contact_total > LIM_MAX) ? LIM_MAX : req_contact_total;
         mask_ff <= req_infectious_mask;
         j_ff    <= '0;
      end
      if (cmd.next_contact) j_ff <= j_ff + sat_pkg::CONTACT_W'(1);
      if (cmd.apply) begin
         case (st_ff)
            sat_pkg::ST_SUS: st_ff <= sat_pkg::ST_EXP;
            sat_pkg::ST_EXP: begin
               st_ff   <= sat_pkg::ST_INF;
               days_ff <= sat_pkg::DAYS_W'(1);
            end
            sat_pkg::ST_INF: st_ff <= sat_pkg::ST_REC;
            default: ;
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_state_ff <= st_ff;
         rsp_days_ff  <= days_ff;
      end
   end

   assign status.seed_last     = (seed_idx_ff == LAST_ADDR);
   assign status.is_sus        = (st_ff == sat_pkg::ST_SUS);
   assign status.is_rec        = (st_ff == sat_pkg::ST_REC);
   assign status.contacts_done = (j_ff >= lim_ff);
   assign status.mask_bit      = mask_ff[j_ff[$clog2(sat_pkg::MASK_W)-1:0]];
   assign status.success       = ({hi_ff, lo_ff} < prob_ff);

   assign rsp_new_state     = rsp_state_ff;
   assign rsp_new_days_sick = rsp_days_ff;

endmodule

// ===== src/sat_ctrl.sv =====
module sat_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          csr_valid,
   input  logic [sat_pkg::CSR_IDX_W-1:0] csr_index,
   output sat_pkg::cmd_type              cmd,
   input  sat_pkg::status_type           status
);

   localparam logic [3:0] S_SEED_INIT = 4'd0;
   localparam logic [3:0] S_SEED_MUL  = 4'd1;
   localparam logic [3:0] S_SEED_ADD  = 4'd2;
   localparam logic [3:0] S_IDLE      = 4'd3;
   localparam logic [3:0] S_DECIDE    = 4'd4;
   localparam logic [3:0] S_RD_LO     = 4'd5;
   localparam logic [3:0] S_GEN_LO    = 4'd6;
   localparam logic [3:0] S_RD_HI     = 4'd7;
   localparam logic [3:0] S_GEN_HI    = 4'd8;
   localparam logic [3:0] S_CMP       = 4'd9;
   localparam logic [3:0] S_FINISH    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_SEED_INIT: begin
            cmd.seed_start = 1'b1;
            state_in       = S_SEED_MUL;
         end
         S_SEED_MUL: begin
            cmd.seed_mul = 1'b1;
            state_in     = S_SEED_ADD;
         end
         S_SEED_ADD: begin
            cmd.seed_add = 1'b1;
            state_in     = status.seed_last ? S_IDLE : S_SEED_MUL;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.is_rec) begin
               state_in = S_FINISH;
            end else if (status.is_sus) begin
               if (status.contacts_done) begin
                  state_in = S_FINISH;
               end else if (status.mask_bit) begin
                  state_in = S_RD_LO;
               end else begin
                  cmd.next_contact = 1'b1;
               end
            end else begin
               state_in = S_RD_LO;
            end
         end
         S_RD_LO: state_in = S_GEN_LO;
         S_GEN_LO: begin
            cmd.gen_lo = 1'b1;
            state_in   = S_RD_HI;
         end
         S_RD_HI: state_in = S_GEN_HI;
         S_GEN_HI: begin
            cmd.gen_hi = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (status.success) begin
               cmd.apply = 1'b1;
               state_in  = S_FINISH;
            end else if (status.is_sus) begin
               cmd.next_contact = 1'b1;
               state_in         = S_DECIDE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output word is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_SEED_INIT;
      endcase
      // new seed restarts the generator fill
      if (csr_valid && csr_index == sat_pkg::CSR_SEED) begin
         state_in = S_SEED_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SEED_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/sat_checker.sv =====
module sat_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sat_pkg::STATE_W-1:0]    rsp_new_state,
   input logic [sat_pkg::DAYS_W-1:0]     rsp_new_days_sick,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [sat_pkg::CSR_IDX_W-1:0]  csr_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_state) &&
                                  $stable(rsp_new_days_sick))
      else $error("result word changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in work");

   a_reset_fill: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken before generator fill");

   a_seed_fill: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == sat_pkg::CSR_SEED |=> !req_ready)
      else $error("request taken during reseed");

endmodule

bind seir_agent_transition_unit sat_checker u_sat_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_new_state     (rsp_new_state),
   .rsp_new_days_sick (rsp_new_days_sick),
   .csr_valid         (csr_valid),
   .csr_ready         (csr_ready),
   .csr_index         (csr_index)
);

// ===== verif/seir_agent_transition_checker.sv =====
`timescale 1ns / 1ps

module seir_agent_transition_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [sat_pkg::STATE_W-1:0]    req_agent_state,
   input  logic [sat_pkg::DAYS_W-1:0]     req_days_sick,
   input  logic [sat_pkg::PROB_W-1:0]     req_catch_prob,
   input  logic [sat_pkg::CONTACT_W-1:0]  req_contact_total,
   input  logic [sat_pkg::MASK_W-1:0]     req_infectious_mask,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [sat_pkg::STATE_W-1:0]    rsp_new_state,
   input  logic [sat_pkg::DAYS_W-1:0]     rsp_new_days_sick,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [sat_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             outstanding
);

   localparam int WORDS = 624;
   localparam int SHIFT = 397;

   typedef struct {
      logic [sat_pkg::STATE_W-1:0] state;
      logic [sat_pkg::DAYS_W-1:0]  days;
   } agent_type;

   agent_type     next_agent_q[$];
   logic [63:0]   gamma_frac;
   logic [63:0]   sigma_frac;
   logic [31:0]   mt_words[WORDS];
   int            mt_pos;

   function automatic void mt_reseed(input logic [31:0] s);
      mt_words[0] = s;
      for (int i = 1; i < WORDS; i++)
         mt_words[i] = 32'd1812433253 * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + 32'(i);
      mt_pos = WORDS;
   endfunction

   function automatic logic [31:0] mt_next();
      logic [31:0] y;
      logic [31:0] v;
      if (mt_pos >= WORDS) begin
         for (int i = 0; i < WORDS; i++) begin
            y = {mt_words[i][31], mt_words[(i + 1) % WORDS][30:0]};
            v = mt_words[(i + SHIFT) % WORDS] ^ (y >> 1);
            if (y[0])
               v = v ^ 32'h9908b0df;
            mt_words[i] = v;
         end
         mt_pos = 0;
      end
      y = mt_words[mt_pos];
      mt_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic draw_hits(input logic [63:0] p);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = mt_next();
      hi = mt_next();
      return {hi, lo} < p;
   endfunction

   function automatic agent_type next_agent(input logic [sat_pkg::STATE_W-1:0] st,
                                            input logic [sat_pkg::DAYS_W-1:0] days,
                                            input logic [63:0] cp,
                                            input logic [sat_pkg::CONTACT_W-1:0] n,
                                            input logic [sat_pkg::MASK_W-1:0] mask);
      agent_type a;
      int        lim;
      logic      caught;
      a.state = st;
      a.days  = days;
      caught  = 1'b0;
      case (st)
         sat_pkg::ST_INF: begin
            if (days != 16'hffff)
               a.days = days + 16'd1;
            if (draw_hits(gamma_frac))
               a.state = sat_pkg::ST_REC;
         end
         sat_pkg::ST_EXP: begin
            if (draw_hits(sigma_frac)) begin
               a.state = sat_pkg::ST_INF;
               a.days  = 16'd1;
            end
         end
         sat_pkg::ST_SUS: begin
            lim = (n > sat_pkg::MAX_CONTACTS) ? sat_pkg::MAX_CONTACTS : int'(n);
            // stop at the first exposure
            for (int j = 0; j < lim; j++)
               if (!caught && j < 16 && mask[j])
                  if (draw_hits(cp))
                     caught = 1'b1;
            if (caught)
               a.state = sat_pkg::ST_EXP;
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      agent_type w;
      if (reset) begin
         fail_count = 0;
         gamma_frac = '0;
         sigma_frac = '0;
         mt_reseed(32'd5489);
         next_agent_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sat_pkg::CSR_RECOVERY:   gamma_frac = csr_data;
               sat_pkg::CSR_INCUBATION: sigma_frac = csr_data;
               sat_pkg::CSR_SEED:       mt_reseed(csr_data[31:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            next_agent_q.push_back(next_agent(req_agent_state, req_days_sick,
               req_catch_prob, req_contact_total, req_infectious_mask));
         if (rsp_valid && rsp_ready) begin
            if (next_agent_q.size() == 0) begin
               report("unexpected word", {30'd0, rsp_new_state}, 32'd0);
            end else begin
               w = next_agent_q.pop_front();
               if (rsp_new_state !== w.state)
                  report("new_state", {30'd0, rsp_new_state}, {30'd0, w.state});
               if (rsp_new_days_sick !== w.days)
                  report("new_days_sick", {16'd0, rsp_new_days_sick}, {16'd0, w.days});
            end
         end
      end
      outstanding = next_agent_q.size();
   end

endmodule

// ===== verif/seir_agent_transition_unit_test.sv =====
`timescale 1ns / 1ps

module seir_agent_transition_unit_test;

   localparam int STUCK_LIMIT = 20000;
   localparam logic [63:0] ONES = '1;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [sat_pkg::STATE_W-1:0]    req_agent_state;
   logic [sat_pkg::DAYS_W-1:0]     req_days_sick;
   logic [sat_pkg::PROB_W-1:0]     req_catch_prob;
   logic [sat_pkg::CONTACT_W-1:0]  req_contact_total;
   logic [sat_pkg::MASK_W-1:0]     req_infectious_mask;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [sat_pkg::STATE_W-1:0]    rsp_new_state;
   logic [sat_pkg::DAYS_W-1:0]     rsp_new_days_sick;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [sat_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sat_pkg::CSR_DATA_W-1:0] csr_data;
   int                             fail_count;
   int                             outstanding;
   int                             send_idle_pct;
   int                             recv_stall_pct;
   int                             stuck_cycles;
   logic                           req_fire;
   logic                           csr_fire;

   seir_agent_transition_unit u_dut (.*);

   seir_agent_transition_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      csr_fire <= csr_valid && csr_ready;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic send_agent(input logic [sat_pkg::STATE_W-1:0] st,
                             input logic [sat_pkg::DAYS_W-1:0] days,
                             input logic [63:0] cp,
                             input logic [sat_pkg::CONTACT_W-1:0] n,
                             input logic [sat_pkg::MASK_W-1:0] mask);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_agent_state     = st;
      req_days_sick       = days;
      req_catch_prob      = cp;
      req_contact_total   = n;
      req_infectious_mask = mask;
      do @(negedge clock); while (!req_fire);
   endtask

   // hold until every word is back, then let the block settle
   task automatic drain();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_csr(input logic [sat_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(negedge clock); while (!csr_fire);
      csr_valid = 1'b0;
   endtask

   function automatic logic [63:0] pick_prob();
      case ($urandom_range(5))
         0: return '0;
         1: return ONES;
         2: return {$urandom, $urandom};
         3: return {32'd0, $urandom};
         4: return {$urandom_range(32'h7fffffff, 32'h0fffffff), $urandom};
         default: return {$urandom_range(32'hffffffff, 32'hc0000000), $urandom};
      endcase
   endfunction

   task automatic random_agent();
      logic [sat_pkg::STATE_W-1:0]   st;
      logic [sat_pkg::CONTACT_W-1:0] n;
      logic [sat_pkg::DAYS_W-1:0]    days;
      logic [sat_pkg::MASK_W-1:0]    mask;
      st   = sat_pkg::STATE_W'($urandom_range(3));
      n    = ($urandom_range(9) == 0) ? sat_pkg::CONTACT_W'($urandom_range(31, 17)) :
             sat_pkg::CONTACT_W'($urandom_range(16));
      days = ($urandom_range(7) == 0) ? 16'hffff : sat_pkg::DAYS_W'($urandom);
      mask = sat_pkg::MASK_W'($urandom);
      send_agent(st, days, pick_prob(), n, mask);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_agent_state = '0;
      req_days_sick = '0;
      req_catch_prob = '0;
      req_contact_total = '0;
      req_infectious_mask = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // zero probabilities or no contacts: no agent changes state
      send_agent(sat_pkg::ST_REC, 16'd7, ONES, 5'd16, 16'hffff);
      send_agent(sat_pkg::ST_INF, 16'd0, '0, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_INF, 16'hffff, '0, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_EXP, 16'd3, ONES, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_SUS, 16'd0, '0, 5'd16, 16'hffff);
      send_agent(sat_pkg::ST_SUS, 16'd9, '0, 5'd31, 16'hffff);
      send_agent(sat_pkg::ST_SUS, 16'd0, ONES, 5'd0, 16'hffff);
      drain();
      write_csr(sat_pkg::CSR_RECOVERY, ONES);
      write_csr(sat_pkg::CSR_INCUBATION, ONES);
      write_csr(sat_pkg::CSR_SPARE, ONES);
      send_agent(sat_pkg::ST_INF, 16'hffff, '0, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_INF, 16'hfffe, '0, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_EXP, 16'hffff, '0, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_SUS, 16'h1234, ONES, 5'd16, 16'hffff);
      send_agent(sat_pkg::ST_SUS, 16'd0, ONES, 5'd20, 16'h8000);
      send_agent(sat_pkg::ST_SUS, 16'd0, ONES, 5'd3, 16'hfff8);
      send_agent(sat_pkg::ST_SUS, 16'd0, 64'd1, 5'd16, 16'h5555);
      drain();
      write_csr(sat_pkg::CSR_SEED, 64'h0);
      send_agent(sat_pkg::ST_SUS, 16'd0, 64'h8000_0000_0000_0000, 5'd16, 16'haaaa);
      send_agent(sat_pkg::ST_EXP, 16'd0, '0, 5'd0, 16'h0);
      drain();
      write_csr(sat_pkg::CSR_SEED, 64'hffffffff);
      write_csr(sat_pkg::CSR_RECOVERY, 64'h8000_0000_0000_0000);
      write_csr(sat_pkg::CSR_INCUBATION, 64'h4000_0000_0000_0000);
      send_agent(sat_pkg::ST_INF, 16'd100, '0, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_EXP, 16'd0, '0, 5'd0, 16'h0);
      send_agent(sat_pkg::ST_SUS, 16'd2, 64'h2000_0000_0000_0000, 5'd16, 16'hffff);

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_csr(sat_pkg::CSR_RECOVERY, pick_prob());
         write_csr(sat_pkg::CSR_INCUBATION, pick_prob());
         write_csr(sat_pkg::CSR_SEED, {32'd0, $urandom});
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         repeat (235) random_agent();
      end
      drain();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
src/sat_pkg.sv
src/sat_ram.sv
src/sat_dp.sv
src/sat_ctrl.sv
src/seir_agent_transition_unit.sv
src/sat_checker.sv
verif/seir_agent_transition_checker.sv
verif/seir_agent_transition_unit_test.sv
